// ===== hdl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Request codes and payload types shared by the slot allocator files.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_DESTROY = 3'd1;
    localparam logic [2:0] REQ_FLUSH   = 3'd2;
    localparam logic [2:0] REQ_ALIVE   = 3'd3;
    localparam logic [2:0] REQ_ADD     = 3'd4;
    localparam logic [2:0] REQ_REMOVE  = 3'd5;
    localparam logic [2:0] REQ_HAS     = 3'd6;
    localparam logic [2:0] REQ_QUERY   = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] slot_index;
        logic [15:0] handle_gen;
        logic [5:0]  component_id;
        logic [63:0] required_mask;
        logic [10:0] cursor;
    } gsa_req_t;

    typedef struct packed {
        logic        ok;
        logic [9:0]  out_index;
        logic [15:0] out_gen;
        logic [10:0] next_cursor;
        logic [10:0] live_total;
        logic [10:0] comp_total;
    } gsa_rsp_t;

endpackage

// ===== hdl/gsa_req_if.sv =====
// ----------------------------------------------------------------------------
// gsa_req_if (its result twin gsa_rsp_if lives in hdl/gsa_rsp_if.sv)
// Valid/ready channel for requests; results travel on gsa_rsp_if.
// ----------------------------------------------------------------------------
interface gsa_req_if
    import gsa_pkg::*;
();
    logic     valid;
    logic     ready;
    gsa_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/gsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gsa_rsp_if
// Valid/ready channel for result items.
// ----------------------------------------------------------------------------
interface gsa_rsp_if
    import gsa_pkg::*;
();
    logic     valid;
    logic     ready;
    gsa_rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/generational_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator_core
// Generational handle allocator with per-slot component masks.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready); one result per request leaves
// on rsp. The block takes one request at a time; req.ready is low while a
// request is in work or its result has not yet been taken.
// Steps per request: alive/has/add/remove read the slot entry, then
// execute; create first pops the free stack or takes a fresh slot, then
// reads its entry; destroy then walks the holder counts one per cycle;
// flush reads each pending slot, fetches its entry, raises its generation
// and pushes it on the free stack; query reads and tests each slot from
// the cursor until a match or the last slot (none if the cursor or mask is out of range).
// After reset a clearing pass writes every slot entry and holder count
// before the first request is taken. A stalled rsp holds the result and
// keeps req.ready low until the transfer.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core
    import gsa_pkg::*;
#(
    parameter int NUM_SLOTS      = 1024,
    parameter int NUM_COMPONENTS = 64,
    parameter int GEN_BITS       = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    gsa_req_if.sink   req,
    gsa_rsp_if.source rsp
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int TW = SW + 1;
    localparam int EW = 1 + GEN_BITS + NUM_COMPONENTS;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_EXEC  = 4'd3;
    localparam logic [3:0] ST_DCNT  = 4'd4;
    localparam logic [3:0] ST_FRD   = 4'd5;
    localparam logic [3:0] ST_FRD2  = 4'd6;
    localparam logic [3:0] ST_FEXE  = 4'd7;
    localparam logic [3:0] ST_QRD   = 4'd8;
    localparam logic [3:0] ST_QEXE  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_CRD   = 4'd11;

    // slot entry: live, gen, mask
    logic              e_we;
    logic [SW-1:0]     e_waddr, e_raddr;
    logic [EW-1:0]     e_wdata, e_rdata;
    logic              f_we;
    logic [SW-1:0]     f_waddr, f_raddr;
    logic [SW-1:0]     f_wdata, f_rdata;
    logic              p_we;
    logic [SW-1:0]     p_waddr, p_raddr;
    logic [SW-1:0]     p_wdata, p_rdata;
    logic              cc_we;
    logic [CW-1:0]     cc_waddr, cc_raddr;
    logic [10:0]       cc_wdata, cc_rdata;

    gsa_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_entry (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    gsa_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));
    gsa_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));
    gsa_ram #(.WIDTH(11), .DEPTH(NUM_COMPONENTS)) u_ccnt (
        .clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
        .raddr(cc_raddr), .rdata(cc_rdata));

    logic [3:0]  state_reg, state_next;
    gsa_req_t    rq_reg, rq_next;
    gsa_rsp_t    rs_reg, rs_next;
    logic [TW-1:0] free_top_reg, free_top_next;
    logic [TW-1:0] fresh_reg, fresh_next;
    logic [TW-1:0] live_reg, live_next;
    logic [TW-1:0] pend_top_reg, pend_top_next;
    logic [TW-1:0] cnt_reg, cnt_next;       // clear / flush / query walker
    logic [CW:0]   cid_reg, cid_next;       // clear / destroy count walker
    logic [SW-1:0] slot_reg, slot_next;
    logic [NUM_COMPONENTS-1:0] mask_reg, mask_next;
    logic          crd_pop_reg;

    logic                      e_live;
    logic [GEN_BITS-1:0]       e_gen;
    logic [NUM_COMPONENTS-1:0] e_mask;
    logic                      idx_ok, cid_ok, alive, held;
    logic [CW-1:0]             cid;
    logic [NUM_COMPONENTS-1:0] cbit, need;
    logic [10:0]               ccur;

    assign e_live = e_rdata[EW-1];
    assign e_gen  = e_rdata[EW-2 -: GEN_BITS];
    assign e_mask = e_rdata[NUM_COMPONENTS-1:0];
    assign idx_ok = ({16'd0, rq_reg.slot_index} < 32'(NUM_SLOTS));
    assign cid_ok = ({26'd0, rq_reg.component_id} < 32'(NUM_COMPONENTS));
    assign cid    = rq_reg.component_id[CW-1:0];
    assign alive  = idx_ok && e_live
                    && ({{(32-GEN_BITS){1'b0}}, e_gen} == {16'd0, rq_reg.handle_gen});
    assign cbit   = NUM_COMPONENTS'(1) << cid;
    assign held   = |(e_mask & cbit);
    assign need   = rq_reg.required_mask[NUM_COMPONENTS-1:0];
    assign ccur   = cc_rdata;

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = (state_reg == ST_DONE);
    assign rsp.payload = rs_reg;

    always_comb
    begin
        logic          need_hi;
        logic [CW-1:0] cid_prev;
        need_hi = 1'b0;
        cid_prev = CW'(cid_reg - (CW+1)'(1));
        state_next    = state_reg;
        rq_next       = rq_reg;
        rs_next       = rs_reg;
        free_top_next = free_top_reg;
        fresh_next    = fresh_reg;
        live_next     = live_reg;
        pend_top_next = pend_top_reg;
        cnt_next      = cnt_reg;
        cid_next      = cid_reg;
        slot_next     = slot_reg;
        mask_next     = mask_reg;
        e_we = 1'b0; e_waddr = slot_reg; e_wdata = '0;
        e_raddr = rq_reg.slot_index[SW-1:0];
        f_we = 1'b0; f_waddr = free_top_reg[SW-1:0]; f_wdata = slot_reg;
        f_raddr = SW'(free_top_reg - TW'(1));
        p_we = 1'b0; p_waddr = pend_top_reg[SW-1:0]; p_wdata = slot_reg;
        p_raddr = cnt_reg[SW-1:0];
        cc_we = 1'b0; cc_waddr = cid; cc_wdata = ccur; cc_raddr = cid;
        if (NUM_COMPONENTS < 64)
        begin
            need_hi = |(rq_reg.required_mask >> NUM_COMPONENTS);
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero slot entries and holder counts, then open for requests
                e_we = (cnt_reg < TW'(NUM_SLOTS));
                e_waddr = cnt_reg[SW-1:0];
                cc_we = (cid_reg < (CW+1)'(NUM_COMPONENTS));
                cc_waddr = cid_reg[CW-1:0];
                cc_wdata = '0;
                if (e_we)
                begin
                    cnt_next = cnt_reg + TW'(1);
                end
                if (cc_we)
                begin
                    cid_next = cid_reg + (CW+1)'(1);
                end
                if (!e_we && !cc_we)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cc_raddr = req.payload.component_id[CW-1:0];
                if (req.valid)
                begin
                    rq_next = req.payload;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rs_next = '0;
                unique case (rq_reg.req_type)
                    REQ_FLUSH:
                    begin
                        cnt_next = '0;
                        state_next = ST_FRD;
                    end
                    REQ_QUERY:
                    begin
                        rs_next.next_cursor = rq_reg.cursor;
                        cnt_next = TW'(rq_reg.cursor);
                        if ({21'd0, rq_reg.cursor} >= 32'(NUM_SLOTS))
                        begin
                            state_next = ST_DONE;
                        end
                        else if (need_hi)
                        begin
                            rs_next.next_cursor = 11'(NUM_SLOTS);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_QRD;
                        end
                    end
                    REQ_CREATE:
                    begin
                        // pop the free stack (read lands next cycle), else take a fresh slot; none left fails
                        if (free_top_reg != '0)
                        begin
                            free_top_next = free_top_reg - TW'(1);
                            state_next = ST_CRD;
                        end
                        else if (fresh_reg < TW'(NUM_SLOTS))
                        begin
                            slot_next = fresh_reg[SW-1:0];
                            fresh_next = fresh_reg + TW'(1);
                            state_next = ST_CRD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_EXEC;
                    end
                endcase
            end
            ST_CRD:
            begin
                // slot from stack read or fresh counter; fetch its entry
                if (crd_pop_reg)
                begin
                    slot_next = f_rdata;
                end
                e_raddr = crd_pop_reg ? f_rdata : slot_reg;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                unique case (rq_reg.req_type)
                    REQ_CREATE:
                    begin
                        e_we = 1'b1;
                        e_wdata = {1'b1, e_gen, {NUM_COMPONENTS{1'b0}}};
                        live_next = live_reg + TW'(1);
                        rs_next.ok = 1'b1;
                        rs_next.out_index = 10'(slot_reg);
                        rs_next.out_gen = 16'(e_gen);
                        state_next = ST_DONE;
                    end
                    REQ_DESTROY:
                    begin
                        if (alive)
                        begin
                            slot_next = rq_reg.slot_index[SW-1:0];
                            e_we = 1'b1;
                            e_waddr = rq_reg.slot_index[SW-1:0];
                            e_wdata = {1'b0, e_gen, {NUM_COMPONENTS{1'b0}}};
                            mask_next = e_mask;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - TW'(1);
                            end
                            p_we = (pend_top_reg < TW'(NUM_SLOTS));
                            p_wdata = rq_reg.slot_index[SW-1:0];
                            if (p_we)
                            begin
                                pend_top_next = pend_top_reg + TW'(1);
                            end
                            rs_next.ok = 1'b1;
                            cid_next = '0;
                            state_next = ST_DCNT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    REQ_ADD:
                    begin
                        if (cid_ok && alive)
                        begin
                            rs_next.ok = 1'b1;
                            if (!held)
                            begin
                                e_we = 1'b1;
                                e_waddr = rq_reg.slot_index[SW-1:0];
                                e_wdata = {1'b1, e_gen, e_mask | cbit};
                                cc_we = 1'b1;
                                cc_wdata = ccur + 11'd1;
                            end
                        end
                        state_next = ST_DONE;
                    end
                    REQ_REMOVE:
                    begin
                        if (cid_ok && alive && held)
                        begin
                            rs_next.ok = 1'b1;
                            e_we = 1'b1;
                            e_waddr = rq_reg.slot_index[SW-1:0];
                            e_wdata = {1'b1, e_gen, e_mask & ~cbit};
                            cc_we = (ccur != 11'd0);
                            cc_wdata = ccur - 11'd1;
                        end
                        state_next = ST_DONE;
                    end
                    REQ_HAS:
                    begin
                        rs_next.ok = cid_ok && alive && held;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        rs_next.ok = alive;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DCNT:
            begin
                // read one holder count per cycle, lower the previous one if the slot held it
                cc_raddr = cid_reg[CW-1:0];
                if (cid_reg != '0)
                begin
                    cc_waddr = cid_prev;
                    cc_wdata = cc_rdata - 11'd1;
                    cc_we = mask_reg[cid_prev] && (cc_rdata != 11'd0);
                    if (cid_ok && cid_prev == cid)
                    begin
                        rs_next.comp_total = cc_we ? cc_wdata : cc_rdata;
                    end
                end
                cid_next = cid_reg + (CW+1)'(1);
                if (cid_reg == (CW+1)'(NUM_COMPONENTS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FRD:
            begin
                if (cnt_reg >= pend_top_reg)
                begin
                    pend_top_next = '0;
                    rs_next.ok = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FRD2;
                end
            end
            ST_FRD2:
            begin
                slot_next = p_rdata;
                e_raddr = p_rdata;
                state_next = ST_FEXE;
            end
            ST_FEXE:
            begin
                e_we = 1'b1;
                e_wdata = {e_live, GEN_BITS'(e_gen + GEN_BITS'(1)), e_mask};
                f_we = (free_top_reg < TW'(NUM_SLOTS));
                if (f_we)
                begin
                    free_top_next = free_top_reg + TW'(1);
                end
                cnt_next = cnt_reg + TW'(1);
                state_next = ST_FRD;
            end
            ST_QRD:
            begin
                e_raddr = cnt_reg[SW-1:0];
                state_next = ST_QEXE;
            end
            ST_QEXE:
            begin
                cnt_next = cnt_reg + TW'(1);
                rs_next.next_cursor = 11'(cnt_reg + TW'(1));
                if (e_live && ((e_mask & need) == need))
                begin
                    rs_next.ok = 1'b1;
                    rs_next.out_index = 10'(cnt_reg);
                    rs_next.out_gen = 16'(e_gen);
                    state_next = ST_DONE;
                end
                else if (cnt_reg == TW'(NUM_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_QRD;
                end
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg != ST_DONE && state_next == ST_DONE)
        begin
            rs_next.live_total = 11'(live_next);
            if (state_reg != ST_DCNT)
            begin
                rs_next.comp_total = cid_ok ? (cc_we && cc_waddr == cid ? cc_wdata : ccur)
                                            : 11'd0;
            end
        end
    end

    // create via free stack: pick up the popped slot from the stack read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crd_pop_reg <= 1'b0;
        end
        else
        begin
            crd_pop_reg <= (state_reg == ST_READ) && (rq_reg.req_type == REQ_CREATE)
                           && (free_top_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            free_top_reg <= '0;
            fresh_reg    <= '0;
            live_reg     <= '0;
            pend_top_reg <= '0;
            cnt_reg      <= '0;
            cid_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            free_top_reg <= free_top_next;
            fresh_reg    <= fresh_next;
            live_reg     <= live_next;
            pend_top_reg <= pend_top_next;
            cnt_reg      <= cnt_next;
            cid_reg      <= cid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg   <= rq_next;
        rs_reg   <= rs_next;
        mask_reg <= mask_next;
        slot_reg <= slot_next;
    end

    ap_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("result changed while stalled");
    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while result pending");
    ap_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= fresh_reg)
        else $error("live count exceeds slots handed out");
    ap_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= fresh_reg && pend_top_reg <= fresh_reg)
        else $error("stack top exceeds slots handed out");

endmodule

// ===== hdl/gsa_ram.sv =====
// ----------------------------------------------------------------------------
// gsa_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
